// ===== rtl/core/icpt_pkg.sv =====
// ----------------------------------------------------------------------------
// icpt_pkg
// Shared types and codes for the interrupt controller with period timer.
// ----------------------------------------------------------------------------
package icpt_pkg;

    // Default number of interrupt lines
    localparam int unsigned NUM_LINES_DEF = 32;

    // System timer source line after reset
    localparam logic [4:0] SYS_LINE_RESET = 5'd1;

    // Low nibble of a timer ie / id write
    localparam logic [3:0] TIMER_BITS = 4'hf;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register selects
    localparam logic [4:0] REG_VECTOR    = 5'd0;
    localparam logic [4:0] REG_STATUS    = 5'd1;
    localparam logic [4:0] REG_MASK      = 5'd2;
    localparam logic [4:0] REG_CORE_STAT = 5'd3;
    localparam logic [4:0] REG_ENABLE    = 5'd4;
    localparam logic [4:0] REG_DISABLE   = 5'd5;
    localparam logic [4:0] REG_CLEAR     = 5'd6;
    localparam logic [4:0] REG_EOI       = 5'd7;
    localparam logic [4:0] REG_TMR_CTRL  = 5'd8;
    localparam logic [4:0] REG_PERIOD    = 5'd9;
    localparam logic [4:0] REG_WDOG_MODE = 5'd10;
    localparam logic [4:0] REG_RT_MODE   = 5'd11;
    localparam logic [4:0] REG_TMR_STAT  = 5'd12;
    localparam logic [4:0] REG_TMR_IE    = 5'd13;
    localparam logic [4:0] REG_TMR_ID    = 5'd14;
    localparam logic [4:0] REG_TMR_MASK  = 5'd15;
    localparam logic [4:0] REG_ALARM     = 5'd16;
    localparam logic [4:0] REG_COUNTER   = 5'd17;

    // Request beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  reg_select;
        logic [31:0] write_data;
    } cmd_beat_t;

    // Response beat
    typedef struct packed {
        logic [31:0] read_data;
        logic        fiq_n;
        logic        irq_n;
        logic        bad_access;
    } rsp_beat_t;

endpackage

// ===== rtl/core/icpt_cmd_if.sv =====
// ----------------------------------------------------------------------------
// icpt_cmd_if
// Valid/ready channel carrying request beats.
// ----------------------------------------------------------------------------
interface icpt_cmd_if;
    import icpt_pkg::*;

    logic      valid;
    logic      ready;
    cmd_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

// ===== rtl/core/icpt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// icpt_rsp_if
// Valid/ready channel carrying response beats.
// ----------------------------------------------------------------------------
interface icpt_rsp_if;
    import icpt_pkg::*;

    logic      valid;
    logic      ready;
    rsp_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

// ===== rtl/core/interrupt_controller_with_period_timer_unit.sv =====
// ----------------------------------------------------------------------------
// interrupt_controller_with_period_timer_unit
// Interrupt controller with pending/mask lines, vector read and a period timer.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  req      | in  | valid/ready   | cmd, reg_select, write_data
//  rsp      | out | valid/ready   | read_data, fiq_n, irq_n, bad_access
//  cfg      | in  | cfg_we        | cfg_data = system_source_line (5 bits)
//
//  One beat per cycle while rsp is not stalled: a request beat is decoded and
//  the controller state is updated at the edge that accepts it; its response
//  is registered at that same edge and offered on rsp from the next cycle.
//  req.ready stays high while the output register is empty or being drained,
//  so a stalled rsp holds its beat and back-pressures req by one beat only.
//  Reset (rst_n low, async) clears all state, levels go inactive (high) and
//  the system source line returns to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module interrupt_controller_with_period_timer_unit #(
    parameter int unsigned NUM_LINES = icpt_pkg::NUM_LINES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    icpt_cmd_if.sink   req,
    icpt_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data
);
    import icpt_pkg::*;

    localparam int unsigned LINE_IDX_W = $clog2(NUM_LINES);

    // Controller state
    logic [NUM_LINES-1:0]  pend_reg, pend_next;
    logic [NUM_LINES-1:0]  mask_reg, mask_next;
    logic [4:0]            last_vec_reg, last_vec_next;
    logic                  fiq_reg, fiq_next;       // active-low levels
    logic                  irq_reg, irq_next;
    logic [4:0]            sys_line_reg, sys_line_next;

    // Timer state
    logic [31:0]           reload_reg, reload_next;
    logic [31:0]           count_reg, count_next;
    logic                  pstat_reg, pstat_next;   // period status, only bit 0 ever sets
    logic [3:0]            tmask_reg, tmask_next;
    logic [31:0]           ticks_reg, ticks_next;
    logic [31:0]           wdog_reg, wdog_next;
    logic [31:0]           rtm_reg, rtm_next;
    logic [31:0]           alarm_reg, alarm_next;

    // Output register
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_beat_t             rsp_beat_reg, rsp_beat_next;

    // Decode helpers
    logic                  req_fire;
    logic                  vec_found;
    logic [LINE_IDX_W-1:0] vec_idx;
    logic [NUM_LINES-1:0]  sys_hot;
    logic [NUM_LINES-1:0]  wr_lines;
    logic [31:0]           rd_data;
    logic                  bad;
    logic                  refresh;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.beat  = rsp_beat_reg;
    assign wr_lines  = req.beat.write_data[NUM_LINES-1:0];

    // Lowest pending line; descending scan leaves the lowest hit
    always_comb
    begin
        vec_found = 1'b0;
        vec_idx   = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                vec_found = 1'b1;
                vec_idx   = LINE_IDX_W'(i);
            end
        end
    end

    // One-hot of the system line; out-of-range lines decode to nothing
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            sys_hot[i] = (sys_line_reg == 5'(i));
        end
    end

    always_comb
    begin
        pend_next     = pend_reg;
        mask_next     = mask_reg;
        last_vec_next = last_vec_reg;
        sys_line_next = sys_line_reg;
        reload_next   = reload_reg;
        count_next    = count_reg;
        pstat_next    = pstat_reg;
        tmask_next    = tmask_reg;
        ticks_next    = ticks_reg;
        wdog_next     = wdog_reg;
        rtm_next      = rtm_reg;
        alarm_next    = alarm_reg;
        fiq_next      = fiq_reg;
        irq_next      = irq_reg;
        rd_data       = '0;
        bad           = 1'b0;
        refresh       = 1'b0;

        if (cfg_we)
        begin
            sys_line_next = cfg_data;
        end

        if (req_fire)
        begin
            case (req.beat.cmd)
                CMD_TICK:
                begin
                    refresh = 1'b1;
                    if (reload_reg != '0)
                    begin
                        if (count_reg == '0)
                        begin
                            // period elapsed: flag, optionally pend, reload
                            pstat_next = 1'b1;
                            if (tmask_reg[0])
                            begin
                                pend_next = pend_reg | sys_hot;
                            end
                            count_next = reload_reg;
                        end
                        else
                        begin
                            ticks_next = ticks_reg + 32'd1;
                            count_next = count_reg - 32'd1;
                        end
                    end
                end
                CMD_READ:
                begin
                    case (req.beat.reg_select)
                        REG_VECTOR:
                        begin
                            // read-to-acknowledge: clear the lowest pending line
                            rd_data       = 32'(vec_idx);
                            last_vec_next = 5'(vec_idx);
                            if (vec_found)
                            begin
                                pend_next[vec_idx] = 1'b0;
                                refresh            = 1'b1;
                            end
                        end
                        REG_STATUS:    rd_data = 32'(last_vec_reg);
                        REG_MASK,
                        REG_CORE_STAT: rd_data = 32'(mask_reg);
                        REG_PERIOD:    rd_data = reload_reg;
                        REG_WDOG_MODE: rd_data = wdog_reg;
                        REG_RT_MODE:   rd_data = rtm_reg;
                        REG_TMR_STAT:
                        begin
                            rd_data    = 32'(pstat_reg);
                            pstat_next = 1'b0;          // clear on read
                        end
                        REG_TMR_MASK:  rd_data = 32'(tmask_reg);
                        REG_ALARM:     rd_data = alarm_reg;
                        REG_COUNTER:   rd_data = ticks_reg;
                        default:       bad     = 1'b1;
                    endcase
                end
                CMD_WRITE:
                begin
                    case (req.beat.reg_select)
                        REG_ENABLE:    mask_next = mask_reg | wr_lines;
                        REG_DISABLE:   mask_next = mask_reg & ~wr_lines;
                        REG_CLEAR:     pend_next = pend_reg & ~wr_lines;
                        REG_EOI:
                        begin
                            pend_next = pend_reg & ~wr_lines;
                            refresh   = 1'b1;
                        end
                        REG_TMR_CTRL:  bad = 1'b0;      // accepted, no watchdog here
                        REG_PERIOD:
                        begin
                            reload_next = req.beat.write_data;
                            count_next  = req.beat.write_data;
                        end
                        REG_WDOG_MODE: wdog_next  = req.beat.write_data;
                        REG_RT_MODE:   rtm_next   = req.beat.write_data;
                        REG_TMR_IE:
                        begin
                            tmask_next = tmask_reg | (req.beat.write_data[3:0] & TIMER_BITS);
                            if (tmask_next != '0)
                            begin
                                pend_next = pend_reg | sys_hot;
                                refresh   = 1'b1;
                            end
                        end
                        REG_TMR_ID:
                            tmask_next = tmask_reg & ~req.beat.write_data[3:0] & TIMER_BITS;
                        REG_ALARM:     alarm_next = req.beat.write_data;
                        default:       bad        = 1'b1;
                    endcase
                end
                default: bad = 1'b1;
            endcase
        end

        // On a refresh, levels follow pending AND mask after the update; line 0 is FIQ
        if (refresh)
        begin
            fiq_next = !(pend_next[0] && mask_next[0]);
            irq_next = !(|(pend_next[NUM_LINES-1:1] & mask_next[NUM_LINES-1:1]));
        end

        rsp_valid_next = req_fire || (rsp_valid_reg && !rsp.ready);
        rsp_beat_next  = rsp_beat_reg;
        if (req_fire)
        begin
            rsp_beat_next.read_data  = bad ? 32'd0 : rd_data;
            rsp_beat_next.fiq_n      = fiq_next;
            rsp_beat_next.irq_n      = irq_next;
            rsp_beat_next.bad_access = bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            mask_reg      <= '0;
            last_vec_reg  <= '0;
            fiq_reg       <= 1'b1;
            irq_reg       <= 1'b1;
            sys_line_reg  <= SYS_LINE_RESET;
            reload_reg    <= '0;
            count_reg     <= '0;
            pstat_reg     <= 1'b0;
            tmask_reg     <= '0;
            ticks_reg     <= '0;
            wdog_reg      <= '0;
            rtm_reg       <= '0;
            alarm_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            mask_reg      <= mask_next;
            last_vec_reg  <= last_vec_next;
            fiq_reg       <= fiq_next;
            irq_reg       <= irq_next;
            sys_line_reg  <= sys_line_next;
            reload_reg    <= reload_next;
            count_reg     <= count_next;
            pstat_reg     <= pstat_next;
            tmask_reg     <= tmask_next;
            ticks_reg     <= ticks_next;
            wdog_reg      <= wdog_next;
            rtm_reg       <= rtm_next;
            alarm_reg     <= alarm_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload, no reset needed
    always_ff @(posedge clk)
    begin
        rsp_beat_reg <= rsp_beat_next;
    end

endmodule

// ===== test/icpt_rsp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icpt_rsp_checker
// Tracks the controller state from accepted request beats and config writes,
// predicts each response beat and compares it field by field when it drains.
// ----------------------------------------------------------------------------
module icpt_rsp_checker
    import icpt_pkg::*;
#(
    parameter int unsigned NUM_LINES = NUM_LINES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  cmd_beat_t  req_beat,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  rsp_beat_t  rsp_beat,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data,
    output int         outstanding,
    output int         mismatches
);

    localparam logic [31:0] LINE_BITS = 32'((64'd1 << NUM_LINES) - 64'd1);
    localparam logic [31:0] FIQ_LINES = 32'h0000_0001;
    localparam logic [31:0] IRQ_LINES = 32'hffff_fffe;

    // mirrored controller state
    logic [4:0]  sys_line;
    logic [31:0] pend_lines;
    logic [31:0] line_en;
    logic [4:0]  last_vec;
    logic        fiq_lvl;
    logic        irq_lvl;
    logic [31:0] reload;
    logic [31:0] countdown;
    logic [3:0]  tmr_stat;
    logic [3:0]  tmr_mask;
    logic [31:0] tick_cnt;
    logic [31:0] wdog_mode;
    logic [31:0] rt_mode;
    logic [31:0] alarm;

    rsp_beat_t   due_rsp_q[$];
    rsp_beat_t   want;

    function automatic void refresh_levels();
        logic [31:0] act;
        act     = pend_lines & line_en;
        fiq_lvl = ((act & FIQ_LINES) == '0);
        irq_lvl = ((act & IRQ_LINES) == '0);
    endfunction

    function automatic void pend_system_line();
        pend_lines = pend_lines | ((32'd1 << sys_line) & LINE_BITS);
    endfunction

    // apply one request beat to the mirrored state, return its response
    function automatic rsp_beat_t predict_response(cmd_beat_t b);
        rsp_beat_t r;
        logic      ok;
        logic      found;
        r  = '0;
        ok = 1'b1;
        case (b.cmd)
            CMD_TICK: begin
                if (reload != '0) begin
                    if (countdown == '0) begin
                        tmr_stat[0] = 1'b1;
                        if (tmr_mask[0])
                            pend_system_line();
                        countdown = reload;
                    end else begin
                        tick_cnt  = tick_cnt + 32'd1;
                        countdown = countdown - 32'd1;
                    end
                end
                refresh_levels();
            end
            CMD_READ: begin
                case (b.reg_select)
                    REG_VECTOR: begin
                        found = 1'b0;
                        for (int i = 0; i < 32; i++) begin
                            if (!found && pend_lines[i]) begin
                                found         = 1'b1;
                                r.read_data   = 32'(i);
                                pend_lines[i] = 1'b0;
                            end
                        end
                        if (found)
                            refresh_levels();
                        last_vec = r.read_data[4:0];
                    end
                    REG_STATUS:    r.read_data = {27'd0, last_vec};
                    REG_MASK:      r.read_data = line_en;
                    REG_CORE_STAT: r.read_data = line_en;
                    REG_PERIOD:    r.read_data = reload;
                    REG_WDOG_MODE: r.read_data = wdog_mode;
                    REG_RT_MODE:   r.read_data = rt_mode;
                    REG_TMR_STAT:
                    begin
                        r.read_data = {28'd0, tmr_stat};
                        tmr_stat    = '0;
                    end
                    REG_TMR_MASK:  r.read_data = {28'd0, tmr_mask};
                    REG_ALARM:     r.read_data = alarm;
                    REG_COUNTER:   r.read_data = tick_cnt;
                    default:       ok = 1'b0;
                endcase
            end
            CMD_WRITE: begin
                case (b.reg_select)
                    REG_ENABLE:    line_en = (line_en | b.write_data) & LINE_BITS;
                    REG_DISABLE:   line_en = line_en & ~b.write_data;
                    REG_CLEAR:     pend_lines = pend_lines & ~b.write_data;
                    REG_EOI:
                    begin
                        pend_lines = pend_lines & ~b.write_data;
                        refresh_levels();
                    end
                    REG_TMR_CTRL:  ;
                    REG_PERIOD:
                    begin
                        reload    = b.write_data;
                        countdown = b.write_data;
                    end
                    REG_WDOG_MODE: wdog_mode = b.write_data;
                    REG_RT_MODE:   rt_mode = b.write_data;
                    REG_TMR_IE:
                    begin
                        tmr_mask = tmr_mask | (b.write_data[3:0] & TIMER_BITS);
                        if (tmr_mask != '0) begin
                            pend_system_line();
                            refresh_levels();
                        end
                    end
                    REG_TMR_ID:    tmr_mask = tmr_mask & ~b.write_data[3:0] & TIMER_BITS;
                    REG_ALARM:     alarm = b.write_data;
                    default:       ok = 1'b0;
                endcase
            end
            default: ok = 1'b0;
        endcase
        if (!ok)
            r.read_data = '0;
        r.fiq_n      = fiq_lvl;
        r.irq_n      = irq_lvl;
        r.bad_access = !ok;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_line   = SYS_LINE_RESET;
            pend_lines = '0;
            line_en    = '0;
            last_vec   = '0;
            fiq_lvl    = 1'b1;
            irq_lvl    = 1'b1;
            reload     = '0;
            countdown  = '0;
            tmr_stat   = '0;
            tmr_mask   = '0;
            tick_cnt   = '0;
            wdog_mode  = '0;
            rt_mode    = '0;
            alarm      = '0;
            due_rsp_q.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                due_rsp_q.push_back(predict_response(req_beat));
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t rsp beat with nothing due: rd=%h fiq_n=%b irq_n=%b bad=%b",
                                 $time, rsp_beat.read_data, rsp_beat.fiq_n,
                                 rsp_beat.irq_n, rsp_beat.bad_access);
                    mismatches++;
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (rsp_beat.read_data !== want.read_data ||
                        rsp_beat.fiq_n !== want.fiq_n ||
                        rsp_beat.irq_n !== want.irq_n ||
                        rsp_beat.bad_access !== want.bad_access)
                    begin
                        if (mismatches < 10)
                            $display("%0t rsp mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
                                     $time, want.read_data, want.fiq_n, want.irq_n,
                                     want.bad_access, rsp_beat.read_data, rsp_beat.fiq_n,
                                     rsp_beat.irq_n, rsp_beat.bad_access);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                sys_line = cfg_data;
            outstanding = due_rsp_q.size();
        end
    end

endmodule

// ===== test/tb_interrupt_controller_with_period_timer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interrupt_controller_with_period_timer_unit
// Regression for the interrupt controller: directed register accesses, then
// random ticks, reads and writes in bursts across several system line settings,
// with a stalling response side; a side checker predicts and compares beats.
// ----------------------------------------------------------------------------
module tb_interrupt_controller_with_period_timer_unit;
    import icpt_pkg::*;

    // long stall on the response side, and the no-progress limit
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_LIMIT     = 3000;
    localparam int RAND_PER_PHASE = 360;

    // command code with no meaning, for the error path
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_data;

    int         outstanding;
    int         mismatches;
    int         sent = 0;
    int         burst_left = 0;
    int         hold_requests = 0;

    icpt_cmd_if req_ch();
    icpt_rsp_if rsp_ch();

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    interrupt_controller_with_period_timer_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    icpt_rsp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_beat    (req_ch.beat),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_beat    (rsp_ch.beat),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    function automatic cmd_beat_t make_req(logic [1:0] c, logic [4:0] sel, logic [31:0] d);
        cmd_beat_t b;
        b.cmd        = c;
        b.reg_select = sel;
        b.write_data = d;
        return b;
    endfunction

    // Random single access. Ticks and reads carry random junk in the unused
    // fields so every request bit toggles. Writes lean toward the registers
    // that move interrupts around; period values stay small so the timer
    // actually wraps.
    function automatic cmd_beat_t rand_request();
        cmd_beat_t b;
        int        r;
        b.cmd        = CMD_TICK;
        b.reg_select = 5'($urandom_range(0, 31));
        b.write_data = $urandom();
        r = $urandom_range(0, 99);
        if (r < 35)
            b.cmd = CMD_TICK;
        else if (r < 65)
        begin
            b.cmd = CMD_READ;
            case ($urandom_range(0, 9))
                0, 1, 2: b.reg_select = REG_VECTOR;
                3:       b.reg_select = REG_TMR_STAT;
                4:       b.reg_select = REG_COUNTER;
                5:       b.reg_select = REG_STATUS;
                default: b.reg_select = 5'($urandom_range(0, REG_COUNTER));
            endcase
        end
        else if (r < 96)
        begin
            b.cmd = CMD_WRITE;
            // single-bit data half the time for the line registers
            if ($urandom_range(0, 1) == 0)
                b.write_data = 32'd1 << $urandom_range(0, 31);
            case ($urandom_range(0, 11))
                0:  b.reg_select = REG_ENABLE;
                1:  b.reg_select = REG_DISABLE;
                2:  b.reg_select = REG_CLEAR;
                3:  b.reg_select = REG_EOI;
                4:
                begin
                    b.reg_select = REG_PERIOD;
                    if ($urandom_range(0, 7) != 0)
                        b.write_data = $urandom_range(0, 6);
                end
                5:  b.reg_select = REG_TMR_IE;
                6:  b.reg_select = REG_TMR_ID;
                7:  b.reg_select = REG_WDOG_MODE;
                8:  b.reg_select = REG_RT_MODE;
                9:  b.reg_select = REG_ALARM;
                10: b.reg_select = REG_TMR_CTRL;
                default: b.reg_select = 5'($urandom_range(0, REG_COUNTER));
            endcase
        end
        else
        begin
            // noise: unknown command, or unknown register select
            if ($urandom_range(0, 1) == 0)
                b.cmd = CMD_UNKNOWN;
            else
            begin
                b.cmd        = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
                b.reg_select = 5'($urandom_range(REG_COUNTER + 1, 31));
            end
        end
        return b;
    endfunction

    // Offer one beat and hold it until accepted. Bursts of random length;
    // a third of the bursts start back to back, the rest after a random gap.
    task automatic send_beat(input cmd_beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.beat  <= b;
        do @(posedge clk); while (!req_ch.ready);
        burst_left--;
        sent++;
    endtask

    // Typical service flow: unmask, arm the period timer and its interrupt, tick
    // it, then read status / vector and signal end of interrupt.
    task automatic run_service_sequence();
        int n;
        send_beat(make_req(CMD_WRITE, REG_ENABLE,
                           ($urandom_range(0, 1) == 0) ? $urandom() : 32'hffff_ffff));
        send_beat(make_req(CMD_WRITE, REG_PERIOD, $urandom_range(1, 4)));
        send_beat(make_req(CMD_WRITE, REG_TMR_IE, {$urandom_range(0, 1) ? 28'd0 :
                           28'($urandom()), 4'($urandom_range(1, 15))}));
        n = $urandom_range(1, 10);
        repeat (n)
            send_beat(make_req(CMD_TICK, 5'($urandom_range(0, 31)), $urandom()));
        send_beat(make_req(CMD_READ, REG_TMR_STAT, $urandom()));
        send_beat(make_req(CMD_READ, REG_VECTOR, $urandom()));
        send_beat(make_req(CMD_READ, REG_STATUS, $urandom()));
        send_beat(make_req(CMD_WRITE, REG_EOI,
                           ($urandom_range(0, 1) == 0) ? 32'd1 << $urandom_range(0, 31) :
                           32'hffff_ffff));
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent + count;
        while (sent < target)
        begin
            if ($urandom_range(0, 3) == 0)
                run_service_sequence();
            else
                send_beat(rand_request());
        end
    endtask

    // Stop offering, wait for every due response, then let the output
    // register settle before touching config.
    task automatic drain_and_settle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    // Response side: segments of always-ready, a fixed stall pattern, or
    // random stalls. On request it holds off for a long stretch so the
    // output register fills and back-pressures the request side.
    initial
    begin : rsp_sink
        int          seg_left;
        int          mode;
        int          holds_done;
        logic [3:0]  step;
        logic [15:0] pat;
        seg_left   = 0;
        mode       = 0;
        holds_done = 0;
        step       = '0;
        pat        = '1;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 200);
                    mode     = $urandom_range(0, 2);
                    pat      = 16'($urandom()) | 16'h0001;
                end
                seg_left--;
                step++;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= pat[step];
                    default: rsp_ch.ready <= ($urandom_range(0, 99) >= 35);
                endcase
            end
        end
    end

    // No-progress watchdog: any handshake on either channel resets it.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("interrupt_controller_with_period_timer_unit regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [4:0] line_sel;
        req_ch.valid <= 1'b0;
        req_ch.beat  <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every register, extreme data, timer wrap, vector with
        // nothing pending, tick with zero period, unknown register / command
        send_beat(make_req(CMD_READ,  REG_VECTOR,    32'h0));
        send_beat(make_req(CMD_TICK,  REG_VECTOR,    32'hffff_ffff));
        send_beat(make_req(CMD_WRITE, REG_ENABLE,    32'hffff_ffff));
        send_beat(make_req(CMD_WRITE, REG_TMR_IE,    32'h0000_000f));
        send_beat(make_req(CMD_READ,  REG_MASK,      32'h0));
        send_beat(make_req(CMD_READ,  REG_CORE_STAT, 32'h0));
        send_beat(make_req(CMD_READ,  REG_VECTOR,    32'h0));
        send_beat(make_req(CMD_READ,  REG_STATUS,    32'h0));
        send_beat(make_req(CMD_WRITE, REG_PERIOD,    32'h1));
        send_beat(make_req(CMD_TICK,  5'd31,         32'h0));
        send_beat(make_req(CMD_TICK,  5'd0,          32'h0));
        send_beat(make_req(CMD_READ,  REG_TMR_STAT,  32'h0));
        send_beat(make_req(CMD_READ,  REG_TMR_STAT,  32'h0));
        send_beat(make_req(CMD_READ,  REG_COUNTER,   32'h0));
        send_beat(make_req(CMD_READ,  REG_PERIOD,    32'h0));
        send_beat(make_req(CMD_WRITE, REG_WDOG_MODE, 32'hffff_ffff));
        send_beat(make_req(CMD_READ,  REG_WDOG_MODE, 32'h0));
        send_beat(make_req(CMD_WRITE, REG_RT_MODE,   32'h0));
        send_beat(make_req(CMD_READ,  REG_RT_MODE,   32'h0));
        send_beat(make_req(CMD_WRITE, REG_ALARM,     32'hffff_ffff));
        send_beat(make_req(CMD_READ,  REG_ALARM,     32'h0));
        send_beat(make_req(CMD_WRITE, REG_TMR_CTRL,  32'hffff_ffff));
        send_beat(make_req(CMD_WRITE, REG_TMR_ID,    32'hffff_ffff));
        send_beat(make_req(CMD_READ,  REG_TMR_MASK,  32'h0));
        send_beat(make_req(CMD_WRITE, REG_CLEAR,     32'hffff_ffff));
        send_beat(make_req(CMD_WRITE, REG_EOI,       32'hffff_ffff));
        send_beat(make_req(CMD_WRITE, REG_DISABLE,   32'hffff_ffff));
        send_beat(make_req(CMD_READ,  5'd31,         32'h0));
        send_beat(make_req(CMD_UNKNOWN, REG_VECTOR,  32'h0));

        // first phase runs with the reset system line
        run_random(RAND_PER_PHASE / 2);

        // system line: FIQ line, top line, something in between, back to reset
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_and_settle();
            case (ph)
                0:       line_sel = 5'd0;
                1:       line_sel = 5'd31;
                2:       line_sel = 5'($urandom_range(2, 30));
                default: line_sel = SYS_LINE_RESET;
            endcase
            cfg_we   <= 1'b1;
            cfg_data <= line_sel;
            @(posedge clk);
            cfg_we <= 1'b0;
            // one long response stall while requests keep coming
            if (ph == 1)
                hold_requests++;
            run_random(RAND_PER_PHASE);
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("interrupt_controller_with_period_timer_unit regression: pass");
        else
            $display("interrupt_controller_with_period_timer_unit regression: fail");
        $finish;
    end

endmodule
